@@ rtl/magpw_pkg.sv @@
// magpw_pkg: shared constants for the magnet point warp unit
// register map and fixed field widths; no dependencies
package magpw_pkg;

   localparam int THR_W  = 33;
   localparam int SF_W   = 15;
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 64;

   localparam logic [1:0] REG_CENTER_X  = 2'd0;
   localparam logic [1:0] REG_CENTER_Y  = 2'd1;
   localparam logic [1:0] REG_THRESHOLD = 2'd2;
   localparam logic [1:0] REG_MODE      = 2'd3;

endpackage

@@ rtl/magnet_point_warp_unit.sv @@
// magnet_point_warp_unit: pipelined magnet falloff warp of one vertex per transfer
// depends on magpw_pkg
//
// Each accepted vertex passes the difference, square, sum, square-root, compare, divider,
// scale, product and saturate registers in that order: one root step per stage for the
// square roots, one quotient bit per stage for the divider. One vertex is taken every
// cycle; the whole pipeline holds while a result waits and rsp_tready is low. Registers
// sit at byte addresses 0 (center_x), 8 (center_y), 16 (threshold) and 24 (mode); the user
// must write them only while no transfer is in flight, as the block does not enforce it.
module magnet_point_warp_unit #(
   parameter int SCALE_SHIFT = 14,
   parameter int COORD_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // point_x, point_y, offset_x, offset_y
   input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // new_x, new_y, scale_factor
   output logic [((2*COORD_WIDTH+magpw_pkg::SF_W+7)/8)*8-1:0] rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [magpw_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [magpw_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [magpw_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                           csr_pready
);

   localparam int CW    = COORD_WIDTH;
   localparam int S     = SCALE_SHIFT;
   localparam int TW    = magpw_pkg::THR_W;
   localparam int DW    = 2*CW + 1;
   localparam int MW    = (DW > TW) ? DW : TW;
   localparam int NR    = (MW + 1) / 2;
   localparam int RW    = 2*NR;
   localparam int PI    = 3 + NR;
   localparam int MI    = PI + S + 2;
   localparam int NT    = MI + 2;
   localparam int OUT_W = ((2*CW+magpw_pkg::SF_W+7)/8)*8;
   localparam int PW    = S + CW + 2;

   // configuration
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic [TW-1:0]        thr_ff;
   logic                 mode_ff;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff   <= '0;
         cy_ff   <= '0;
         thr_ff  <= '0;
         mode_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_paddr[4:3])
            magpw_pkg::REG_CENTER_X:  cx_ff   <= csr_pwdata[CW-1:0];
            magpw_pkg::REG_CENTER_Y:  cy_ff   <= csr_pwdata[CW-1:0];
            magpw_pkg::REG_THRESHOLD: thr_ff  <= csr_pwdata[TW-1:0];
            magpw_pkg::REG_MODE:      mode_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:3])
         magpw_pkg::REG_CENTER_X:  csr_prdata = magpw_pkg::CSR_DW'(cx_ff);
         magpw_pkg::REG_CENTER_Y:  csr_prdata = magpw_pkg::CSR_DW'(cy_ff);
         magpw_pkg::REG_THRESHOLD: csr_prdata = magpw_pkg::CSR_DW'(thr_ff);
         magpw_pkg::REG_MODE:      csr_prdata = magpw_pkg::CSR_DW'(mode_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic [NT-1:0]   vld_ff;
   logic [4*CW-1:0] car_ff [NT];
   logic            en;

   assign en         = !vld_ff[NT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[NT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         car_ff[0] <= req_tdata[4*CW-1:0];
         for (int i = 1; i < NT; i++) begin
            car_ff[i] <= car_ff[i-1];
         end
      end
   end

   // stage 0: differences, stage 1: squares, stage 2: sum
   logic signed [CW:0]      dx_ff, dy_ff;
   logic signed [2*CW+1:0]  sqx_in, sqy_in;
   logic [2*CW-1:0]         sqx_ff, sqy_ff;
   logic [RW-1:0] rvd_ff [NR+1];
   logic [RW-1:0] rrd_ff [NR+1];
   logic [RW-1:0] rvt_ff [NR+1];
   logic [RW-1:0] rrt_ff [NR+1];
   logic [MW-1:0] rawd_ff [NR+1];
   logic [MW-1:0] rawt_ff [NR+1];

   assign sqx_in = dx_ff * dx_ff;
   assign sqy_in = dy_ff * dy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= $signed({cx_ff[CW-1], cx_ff}) -
                  $signed({req_tdata[CW-1], req_tdata[CW-1:0]});
         dy_ff <= $signed({cy_ff[CW-1], cy_ff}) -
                  $signed({req_tdata[2*CW-1], req_tdata[2*CW-1:CW]});
         sqx_ff <= sqx_in[2*CW-1:0];
         sqy_ff <= sqy_in[2*CW-1:0];
         rvd_ff[0]  <= RW'({1'b0, sqx_ff} + {1'b0, sqy_ff});
         rawd_ff[0] <= MW'({1'b0, sqx_ff} + {1'b0, sqy_ff});
         rrd_ff[0]  <= '0;
         rvt_ff[0]  <= RW'(thr_ff);
         rawt_ff[0] <= MW'(thr_ff);
         rrt_ff[0]  <= '0;
      end
   end

   // floor square roots, one step per stage
   for (genvar k = 1; k <= NR; k++) begin : g_root
      localparam logic [RW-1:0] BITK = RW'(1) << (2*(NR-k));
      logic [RW-1:0] sd, st, vd_in, rd_in, vt_in, rt_in;
      always_comb begin
         sd = rrd_ff[k-1] + BITK;
         st = rrt_ff[k-1] + BITK;
         if (rvd_ff[k-1] >= sd) begin
            vd_in = rvd_ff[k-1] - sd;
            rd_in = (rrd_ff[k-1] >> 1) + BITK;
         end else begin
            vd_in = rvd_ff[k-1];
            rd_in = rrd_ff[k-1] >> 1;
         end
         if (rvt_ff[k-1] >= st) begin
            vt_in = rvt_ff[k-1] - st;
            rt_in = (rrt_ff[k-1] >> 1) + BITK;
         end else begin
            vt_in = rvt_ff[k-1];
            rt_in = rrt_ff[k-1] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rvd_ff[k]  <= vd_in;
            rrd_ff[k]  <= rd_in;
            rvt_ff[k]  <= vt_in;
            rrt_ff[k]  <= rt_in;
            rawd_ff[k] <= rawd_ff[k-1];
            rawt_ff[k] <= rawt_ff[k-1];
         end
      end
   end

   // compare, then restoring division one quotient bit per stage
   logic [MW:0]   rem_ff  [S+1];
   logic [MW-1:0] dv_ff   [S+1];
   logic [S-1:0]  q_ff    [S+1];
   logic          full_ff [S+1];
   logic [MW-1:0] dsel_in, tsel_in;

   assign dsel_in = mode_ff ? MW'(rrd_ff[NR]) : rawd_ff[NR];
   assign tsel_in = mode_ff ? MW'(rrt_ff[NR]) : rawt_ff[NR];

   always_ff @(posedge clock) begin
      if (en) begin
         full_ff[0] <= dsel_in <= tsel_in;
         rem_ff[0]  <= {1'b0, tsel_in};
         dv_ff[0]   <= dsel_in;
         q_ff[0]    <= '0;
      end
   end

   for (genvar k = 1; k <= S; k++) begin : g_div
      logic [MW:0]  r2, rem_in;
      logic [S-1:0] q_in;
      always_comb begin
         r2 = {rem_ff[k-1][MW-1:0], 1'b0};
         if (r2 >= {1'b0, dv_ff[k-1]}) begin
            rem_in = r2 - {1'b0, dv_ff[k-1]};
            q_in   = {q_ff[k-1][S-2:0], 1'b1};
         end else begin
            rem_in = r2;
            q_in   = {q_ff[k-1][S-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            q_ff[k]    <= q_in;
            dv_ff[k]   <= dv_ff[k-1];
            full_ff[k] <= full_ff[k-1];
         end
      end
   end

   // scale times offset
   localparam logic [S:0] FULL = (S+1)'(1) << S;
   logic [S:0]             scale_in, scale_ff, scale_o_ff;
   logic signed [S+1:0]    sc_s;
   logic signed [CW-1:0]   ox, oy;
   logic signed [PW-1:0]   prx_ff, pry_ff;

   assign scale_in = full_ff[S] ? FULL : {1'b0, q_ff[S]};
   assign sc_s     = $signed({1'b0, scale_ff});
   assign ox       = car_ff[MI-1][3*CW-1:2*CW];
   assign oy       = car_ff[MI-1][4*CW-1:3*CW];

   always_ff @(posedge clock) begin
      if (en) begin
         scale_ff <= scale_in;
      end
   end

   // scale_ff belongs to stage MI-1; product registered at stage MI
   always_ff @(posedge clock) begin
      if (en) begin
         prx_ff     <= sc_s * ox;
         pry_ff     <= sc_s * oy;
         scale_o_ff <= scale_ff;
      end
   end

   // add and saturate
   logic signed [PW-1:0] shx, shy;
   logic signed [CW+1:0] sumx, sumy;
   logic [CW-1:0]        nx_in, ny_in, nx_ff, ny_ff;
   logic [15:0]          sc16;
   logic [magpw_pkg::SF_W-1:0] sf_ff;
   logic [CW-1:0]        px, py;

   assign px   = car_ff[MI][CW-1:0];
   assign py   = car_ff[MI][2*CW-1:CW];
   assign shx  = prx_ff >>> S;
   assign shy  = pry_ff >>> S;
   assign sumx = $signed({{2{px[CW-1]}}, px}) + $signed(shx[CW+1:0]);
   assign sumy = $signed({{2{py[CW-1]}}, py}) + $signed(shy[CW+1:0]);
   assign sc16 = 16'(scale_o_ff);

   always_comb begin
      if (sumx[CW+1:CW-1] == 3'b000 || sumx[CW+1:CW-1] == 3'b111) begin
         nx_in = sumx[CW-1:0];
      end else begin
         nx_in = sumx[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
      if (sumy[CW+1:CW-1] == 3'b000 || sumy[CW+1:CW-1] == 3'b111) begin
         ny_in = sumy[CW-1:0];
      end else begin
         ny_in = sumy[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         sf_ff <= sc16[magpw_pkg::SF_W-1:0];
      end
   end

   assign rsp_tdata = OUT_W'({sf_ff, ny_ff, nx_ff});

   a_scale_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[MI-1] |-> scale_ff <= FULL)
      else $error("scale above full");
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted transfer lost");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

endmodule

@@ test/magnet_point_warp_unit_tb.sv @@
// magnet_point_warp_unit_tb: self-checking bench for the magnet point warp unit
// drives vertex transfers and apb register writes, predicts each warped vertex and scale
// depends on magpw_pkg and rtl/magnet_point_warp_unit.sv
module magnet_point_warp_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SHIFT = 14;
   localparam int CW = 16;
   localparam int LIMIT = 20000;
   localparam int AW = magpw_pkg::CSR_AW;
   localparam int DW = magpw_pkg::CSR_DW;

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic [14:0]        sf;
   } warp_type;

   class warp_board;
      logic signed [15:0] cx, cy;
      logic [32:0]        thr;
      logic               lin;
      warp_type           pending[$];
      int                 errors;

      function new();
         cx = 0; cy = 0; thr = 0; lin = 0; errors = 0;
      endfunction

      function longint unsigned root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function longint shift_floor(longint unsigned s, longint o);
         longint p;
         p = longint'(s) * o;
         return p >>> SHIFT;
      endfunction

      function logic signed [15:0] clamp(longint v);
         if (v > 32767) return 16'sh7fff;
         if (v < -32768) return 16'sh8000;
         return v[15:0];
      endfunction

      function void note_vertex(logic signed [15:0] px, py, ox, oy);
         longint dx, dy;
         longint unsigned d, t, s;
         warp_type w;
         dx = longint'(cx) - longint'(px);
         dy = longint'(cy) - longint'(py);
         d = dx * dx + dy * dy;
         t = 64'(thr);
         if (lin) begin
            d = root(d);
            t = root(t);
         end
         s = (d <= t) ? (64'd1 << SHIFT) : ((64'd1 << SHIFT) * t) / d;
         w.nx = clamp(longint'(px) + shift_floor(s, ox));
         w.ny = clamp(longint'(py) + shift_floor(s, oy));
         w.sf = s[14:0];
         pending.push_back(w);
      endfunction

      function void check_result(warp_type got);
         warp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.nx !== e.nx) begin
            $error("new_x expected %0d got %0d", e.nx, got.nx);
            errors++;
         end
         if (got.ny !== e.ny) begin
            $error("new_y expected %0d got %0d", e.ny, got.ny);
            errors++;
         end
         if (got.sf !== e.sf) begin
            $error("scale_factor expected %0d got %0d", e.sf, got.sf);
            errors++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [63:0] req_tdata;
   logic [47:0] rsp_tdata;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [AW-1:0] csr_paddr;
   logic [DW-1:0] csr_pwdata, csr_prdata;

   warp_board board;
   int send_idle, stall_pct, quiet;

   magnet_point_warp_unit #(.SCALE_SHIFT(SHIFT), .COORD_WIDTH(CW)) i_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // result side: random stall, check on transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result({rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[46:32]});
   end

   always @(negedge clock)
      rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet > LIMIT) begin
         $display("magnet_point_warp_unit: mismatch");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= AW'(idx) << 3; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         magpw_pkg::REG_CENTER_X:  board.cx = val[15:0];
         magpw_pkg::REG_CENTER_Y:  board.cy = val[15:0];
         magpw_pkg::REG_THRESHOLD: board.thr = val[32:0];
         magpw_pkg::REG_MODE:      board.lin = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   // tvalid stays high after the transfer so the next call can follow at once
   task automatic send_vertex(logic [15:0] px, py, ox, oy);
      @(negedge clock);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {oy, ox, py, px};
      do @(posedge clock); while (!req_tready);
      board.note_vertex(px, py, ox, oy);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_all(logic [15:0] x, y, logic [32:0] t, logic m);
      write_reg(magpw_pkg::REG_CENTER_X, 64'(x));
      write_reg(magpw_pkg::REG_CENTER_Y, 64'(y));
      write_reg(magpw_pkg::REG_THRESHOLD, 64'(t));
      write_reg(magpw_pkg::REG_MODE, 64'(m));
   endtask

   function automatic logic [15:0] near_coord(logic [15:0] c);
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return c + 16'($urandom_range(0, 400)) - 16'd200;
         2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         default: return c + 16'($urandom_range(0, 8000)) - 16'd4000;
      endcase
   endfunction

   initial begin
      logic [32:0] t;
      board = new();
      reset = 1; req_tvalid = 0; req_tdata = 0; rsp_tready = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      send_idle = 0; stall_pct = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: centre hit, zero threshold, saturation, extremes
      send_vertex(16'd0, 16'd0, 16'h7fff, 16'h8000);
      send_vertex(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_vertex(16'd5, -16'sd3, 16'd100, -16'sd100);
      drain();
      set_all(16'h8000, 16'h7fff, 33'h1ffffffff, 1'b1);
      send_vertex(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
      send_vertex(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
      send_vertex(16'h7000, 16'h9000, 16'h7fff, 16'h8000);
      drain();
      set_all(16'd100, -16'sd200, 33'd10000, 1'b0);
      send_vertex(16'd100, -16'sd200, 16'h8000, 16'h7fff);
      send_vertex(16'd200, -16'sd200, 16'd50, -16'sd50);
      send_vertex(16'd201, -16'sd200, 16'h7fff, 16'h8000);
      send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_vertex(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_vertex(16'h7ff0, 16'd0, 16'h7fff, 16'd1);
      drain();
      write_reg(magpw_pkg::REG_MODE, 64'd1);
      send_vertex(16'd201, -16'sd200, 16'h7fff, 16'h8000);
      send_vertex(16'h8000, 16'h7fff, -16'sd1, 16'd1);
      send_vertex(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         send_idle = (ph % 4 == 1 || ph % 4 == 3) ? 67 : 0;
         stall_pct = (ph % 4 == 2) ? 67 : (ph % 4 == 3) ? 11 : 0;
         if (ph % 4 == 3) send_idle = 11;
         case ($urandom_range(3))
            0: t = 0;
            1: t = 33'h1ffffffff;
            2: t = 33'($urandom_range(0, 100000));
            default: t = {1'($urandom_range(1)), $urandom};
         endcase
         drain();
         set_all(16'($urandom), 16'($urandom), t, ph[0]);
         for (int n = 0; n < 80; n++) begin
            send_vertex(near_coord(board.cx), near_coord(board.cy),
                        16'($urandom), 16'($urandom));
            if (n == 40 && ph == 2)
               drain();
         end
      end

      drain();
      if (board.errors == 0)
         $display("magnet_point_warp_unit: match");
      else
         $display("magnet_point_warp_unit: mismatch");
      $finish;
   end
endmodule
